/* rtl/core/back_forward_history_stacks_macros.svh */
// Assertion helpers used by the history stack datapath.
// All use i_clk and the active-low synchronous reset i_rst_n of the including module.
`ifndef BACK_FORWARD_HISTORY_STACKS_MACROS_SVH
`define BACK_FORWARD_HISTORY_STACKS_MACROS_SVH

// cons must hold in the same cycle as ante
`define BFHS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfhs assertion failed");

// cons must hold in the cycle after ante
`define BFHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfhs assertion failed");

`endif

/* rtl/core/bfhs_pkg.sv */
`default_nettype none

package bfhs_pkg;

    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_HANDLE_BITS = 32;

    typedef enum logic [1:0] {
        CMD_VISIT   = 2'd0,
        CMD_BACK    = 2'd1,
        CMD_FORWARD = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_BACK    = 2'd1,
        STAT_NO_FORWARD = 2'd2,
        STAT_FULL       = 2'd3
    } t_status;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // capture the input transaction, top-of-stack reads in flight
        logic exec;   // apply the command and load the result register
    } t_ctl;

endpackage

`default_nettype wire

/* rtl/core/bfhs_ctrl.sv */
`default_nettype none

module bfhs_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output bfhs_pkg::t_ctl   o_ctl
);
    import bfhs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_ctl.load = 1'b0;
        o_ctl.exec = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait here while the previous result is still held downstream
                if (slot_free) begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bfhs_datapath.sv */
`default_nettype none

`include "back_forward_history_stacks_macros.svh"

module bfhs_datapath #(
    parameter int STACK_DEPTH = 1024,
    parameter int HANDLE_BITS = 32,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  bfhs_pkg::t_ctl            i_ctl,
    input  wire [1:0]                 i_command,
    input  wire [HANDLE_BITS-1:0]     i_page_handle,
    output logic [HANDLE_BITS-1:0]    o_current_page,
    output logic                      o_current_valid,
    output logic [1:0]                o_status,
    output logic [CNT_W-1:0]          o_back_depth,
    output logic [CNT_W-1:0]          o_forward_depth
);
    import bfhs_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    logic [HANDLE_BITS-1:0] back_mem [STACK_DEPTH];
    logic [HANDLE_BITS-1:0] fwd_mem  [STACK_DEPTH];

    t_cmd                   r_cmd;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [CNT_W-1:0]       r_back_count, n_back_count;
    logic [CNT_W-1:0]       r_fwd_count, n_fwd_count;
    logic [HANDLE_BITS-1:0] r_cur, n_cur;
    logic                   r_cur_valid, n_cur_valid;
    logic [HANDLE_BITS-1:0] r_back_top, r_fwd_top;
    t_status                n_status;

    logic [HANDLE_BITS-1:0] r_out_page;
    logic                   r_out_valid_bit;
    t_status                r_out_status;
    logic [CNT_W-1:0]       r_out_back, r_out_fwd;

    logic                   back_we, fwd_we;
    logic [CNT_W-1:0]       back_top_idx, fwd_top_idx;
    logic                   back_full, fwd_full;

    assign back_full    = (r_back_count == FULL_CNT);
    assign fwd_full     = (r_fwd_count == FULL_CNT);
    assign back_top_idx = r_back_count - CNT_W'(1);
    assign fwd_top_idx  = r_fwd_count - CNT_W'(1);

    always_comb begin
        n_back_count = r_back_count;
        n_fwd_count  = r_fwd_count;
        n_cur        = r_cur;
        n_cur_valid  = r_cur_valid;
        n_status     = STAT_OK;
        back_we      = 1'b0;
        fwd_we       = 1'b0;
        case (r_cmd)
            CMD_VISIT: begin
                if (r_cur_valid) begin
                    if (back_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        back_we      = 1'b1;
                        n_back_count = r_back_count + CNT_W'(1);
                    end
                end
                n_cur       = r_handle;
                n_cur_valid = 1'b1;
                n_fwd_count = '0;
            end
            CMD_BACK: begin
                if (r_back_count == '0) begin
                    n_status = STAT_NO_BACK;
                end else begin
                    if (fwd_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        fwd_we      = 1'b1;
                        n_fwd_count = r_fwd_count + CNT_W'(1);
                    end
                    n_cur        = r_back_top;
                    n_cur_valid  = 1'b1;
                    n_back_count = r_back_count - CNT_W'(1);
                end
            end
            CMD_FORWARD: begin
                if (r_fwd_count == '0) begin
                    n_status = STAT_NO_FORWARD;
                end else begin
                    if (back_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        back_we      = 1'b1;
                        n_back_count = r_back_count + CNT_W'(1);
                    end
                    n_cur       = r_fwd_top;
                    n_cur_valid = 1'b1;
                    n_fwd_count = r_fwd_count - CNT_W'(1);
                end
            end
            default: n_status = STAT_OK;
        endcase
    end

    // Stacks: one write and one registered top-of-stack read per cycle.
    // Counts only move on exec, so the read taken at load time is the current top.
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && back_we) begin
            back_mem[r_back_count[AW-1:0]] <= r_cur;
        end
        r_back_top <= back_mem[back_top_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && fwd_we) begin
            fwd_mem[r_fwd_count[AW-1:0]] <= r_cur;
        end
        r_fwd_top <= fwd_mem[fwd_top_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= t_cmd'(i_command);
            r_handle <= i_page_handle;
        end
        if (i_ctl.exec) begin
            r_out_page      <= n_cur;
            r_out_valid_bit <= n_cur_valid;
            r_out_status    <= n_status;
            r_out_back      <= n_back_count;
            r_out_fwd       <= n_fwd_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_count <= '0;
            r_fwd_count  <= '0;
            r_cur        <= '0;
            r_cur_valid  <= 1'b0;
        end else if (i_ctl.exec) begin
            r_back_count <= n_back_count;
            r_fwd_count  <= n_fwd_count;
            r_cur        <= n_cur;
            r_cur_valid  <= n_cur_valid;
        end
    end

    assign o_current_page  = r_out_page;
    assign o_current_valid = r_out_valid_bit;
    assign o_status        = r_out_status;
    assign o_back_depth    = r_out_back;
    assign o_forward_depth = r_out_fwd;

    `BFHS_ASSERT_NOW(a_depth_bound, 1'b1, (r_back_count <= FULL_CNT) && (r_fwd_count <= FULL_CNT))
    `BFHS_ASSERT_NEXT(a_visit_clears_fwd, i_ctl.exec && (r_cmd == CMD_VISIT), r_fwd_count == '0)
    `BFHS_ASSERT_NEXT(a_empty_back_holds, i_ctl.exec && (r_cmd == CMD_BACK) && (r_back_count == '0), $stable(r_back_count) && $stable(r_fwd_count) && $stable(r_cur))
    `BFHS_ASSERT_NOW(a_single_push, i_ctl.exec, !(back_we && fwd_we))

endmodule

`default_nettype wire

/* rtl/core/back_forward_history_stacks.sv */
// Navigation history: a current page handle plus bounded back and forward stacks.
// Input stream: tuser carries the command (visit, back, forward), tdata the page
// handle, which only a visit uses. Output stream: one result per command with
// the current handle, its valid bit, a status code and both stack depths.
// The input transaction is captured first; the command is then applied and the
// result register loads as soon as the output register is free.
// Each command is handled in order: both stack tops are read from their memories
// (registered read), then the command is applied; a new input waits until then.
// A result waiting in the output register does not block the next input
// transaction; if it is still held when that command is ready to apply, the
// block waits in the apply step, and input ready stays low until it can go on.
// Back on an empty back stack or forward on an empty forward stack changes
// nothing and reports a status. A push onto a full stack is dropped and flagged,
// the rest of the move still happens.
// Reset clears both depths, the current handle and its valid bit; stack memory
// contents are left as they are and are never used before being written.
`default_nettype none

module back_forward_history_stacks #(
    parameter int STACK_DEPTH = bfhs_pkg::DEF_STACK_DEPTH,
    parameter int HANDLE_BITS = bfhs_pkg::DEF_HANDLE_BITS,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1),
    parameter int IN_TDATA_W  = ((HANDLE_BITS + 7) / 8) * 8,
    parameter int OUT_TDATA_W = ((HANDLE_BITS + 2 * CNT_W + 7) / 8) * 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   i_s_axis_tdata,   // page_handle, zero pad
    input  wire [1:0]              i_s_axis_tuser,   // command
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // current_page, back_depth, forward_depth, zero pad
    output logic [2:0]             o_m_axis_tuser    // current_valid, status
);
    import bfhs_pkg::*;

    t_ctl                   ctl;
    logic [HANDLE_BITS-1:0] cur_page;
    logic                   cur_valid;
    logic [1:0]             status;
    logic [CNT_W-1:0]       back_depth, fwd_depth;

    bfhs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_ctl       (ctl)
    );

    bfhs_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .HANDLE_BITS (HANDLE_BITS),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_command       (i_s_axis_tuser),
        .i_page_handle   (i_s_axis_tdata[HANDLE_BITS-1:0]),
        .o_current_page  (cur_page),
        .o_current_valid (cur_valid),
        .o_status        (status),
        .o_back_depth    (back_depth),
        .o_forward_depth (fwd_depth)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({fwd_depth, back_depth, cur_page});
    assign o_m_axis_tuser = {status, cur_valid};

endmodule

`default_nettype wire

/* tb/tb_back_forward_history_stacks.sv */
module tb_back_forward_history_stacks;
    timeunit 1ns;
    timeprecision 1ps;

    import bfhs_pkg::*;

    localparam int DEPTH       = DEF_STACK_DEPTH;
    localparam int RAND_ITEMS  = 120;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [31:0] page;
        logic        valid;
        t_status     status;
        logic [10:0] back_depth;
        logic [10:0] fwd_depth;
    } t_nav_view;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_tdata = '0;   // page_handle
    logic [1:0]  s_tuser = '0;   // command
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [55:0] m_tdata;        // current_page, back_depth, forward_depth, zero pad
    logic [2:0]  m_tuser;        // current_valid, status

    back_forward_history_stacks u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // history model state
    logic [31:0] back_pages [DEPTH];
    logic [31:0] fwd_pages  [DEPTH];
    logic [10:0] back_cnt = '0;
    logic [10:0] fwd_cnt  = '0;
    logic [31:0] cur_page = '0;
    logic        cur_valid = 1'b0;

    t_nav_view pending_views [$];
    int  errors = 0;
    int  results_seen = 0;
    int  full_drops = 0;
    int  cycle_cnt = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Applies one navigation command to the model and queues the view it yields.
    task automatic apply_nav_cmd(input t_cmd cmd, input logic [31:0] handle);
        t_status st;
        st = STAT_OK;
        case (cmd)
            CMD_VISIT: begin
                if (cur_valid) begin
                    if (back_cnt >= DEPTH) begin
                        st = STAT_FULL;
                    end else begin
                        back_pages[back_cnt] = cur_page;
                        back_cnt++;
                    end
                end
                cur_page  = handle;
                cur_valid = 1'b1;
                fwd_cnt   = '0;
            end
            CMD_BACK: begin
                if (back_cnt == 0) begin
                    st = STAT_NO_BACK;
                end else begin
                    if (fwd_cnt >= DEPTH) begin
                        st = STAT_FULL;
                    end else begin
                        fwd_pages[fwd_cnt] = cur_page;
                        fwd_cnt++;
                    end
                    back_cnt--;
                    cur_page  = back_pages[back_cnt];
                    cur_valid = 1'b1;
                end
            end
            CMD_FORWARD: begin
                if (fwd_cnt == 0) begin
                    st = STAT_NO_FORWARD;
                end else begin
                    if (back_cnt >= DEPTH) begin
                        st = STAT_FULL;
                    end else begin
                        back_pages[back_cnt] = cur_page;
                        back_cnt++;
                    end
                    fwd_cnt--;
                    cur_page  = fwd_pages[fwd_cnt];
                    cur_valid = 1'b1;
                end
            end
            default: ;
        endcase
        if (st == STAT_FULL)
            full_drops++;
        pending_views.push_back('{cur_page, cur_valid, st, back_cnt, fwd_cnt});
    endtask

    // valid stays high across back-to-back transactions; it drops only for a gap
    task automatic send_cmd(input t_cmd cmd, input logic [31:0] handle);
        int gap;
        gap = pick_gap(tx_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= handle;
        do @(posedge i_clk); while (!s_ready);
        apply_nav_cmd(cmd, handle);
    endtask

    task automatic test_empty_history();
        send_cmd(CMD_BACK, 32'h1234_5678);
        send_cmd(CMD_FORWARD, 32'h8765_4321);
    endtask

    task automatic test_visit_extremes();
        // first visit has nothing current, so nothing is pushed
        send_cmd(CMD_VISIT, 32'h0000_0000);
        send_cmd(CMD_VISIT, 32'hFFFF_FFFF);
        send_cmd(CMD_VISIT, 32'hAAAA_AAAA);
        send_cmd(CMD_VISIT, 32'h5555_5555);
        send_cmd(CMD_VISIT, 32'h0000_0001);
        send_cmd(CMD_VISIT, 32'h8000_0000);
    endtask

    task automatic test_back_forward();
        send_cmd(CMD_BACK, $urandom());
        send_cmd(CMD_BACK, $urandom());
        send_cmd(CMD_FORWARD, $urandom());
        send_cmd(CMD_FORWARD, $urandom());
        send_cmd(CMD_FORWARD, $urandom());      // forward stack empty
        repeat (5) send_cmd(CMD_BACK, $urandom());
        send_cmd(CMD_BACK, $urandom());         // back stack empty
        send_cmd(CMD_FORWARD, $urandom());
        send_cmd(CMD_VISIT, $urandom());        // clears forward stack
    endtask

    task automatic test_random_nav();
        int r;
        logic [31:0] handle;
        t_cmd cmd;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 100 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            cmd = (r < 38) ? CMD_VISIT : (r < 70) ? CMD_BACK : CMD_FORWARD;
            if ($urandom_range(0, 15) == 0)
                handle = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            else
                handle = $urandom();
            send_cmd(cmd, handle);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_back_stack_full();
        while (back_cnt < DEPTH)
            send_cmd(CMD_VISIT, $urandom());
        // pushes onto a full back stack are dropped, current still moves
        repeat (3) send_cmd(CMD_VISIT, $urandom());
        send_cmd(CMD_BACK, $urandom());
        send_cmd(CMD_FORWARD, $urandom());
        send_cmd(CMD_VISIT, $urandom());
    endtask

    // output stall pattern
    initial begin : rx_ready_proc
        int stall;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = pick_gap(rx_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_nav_view want;
        t_nav_view got;
        if (i_rst_n && m_valid && m_ready) begin
            got = '{m_tdata[31:0], m_tuser[0], t_status'(m_tuser[2:1]),
                    m_tdata[42:32], m_tdata[53:43]};
            results_seen++;
            if (pending_views.size() == 0) begin
                $display("%0t: unexpected result page=%h valid=%b status=%0d bd=%0d fd=%0d",
                         $time, got.page, got.valid, got.status, got.back_depth,
                         got.fwd_depth);
                errors++;
            end else begin
                want = pending_views.pop_front();
                if (got.page !== want.page) begin
                    $display("%0t: current_page expected %h actual %h",
                             $time, want.page, got.page);
                    errors++;
                end
                if (got.valid !== want.valid) begin
                    $display("%0t: current_valid expected %b actual %b",
                             $time, want.valid, got.valid);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.back_depth !== want.back_depth) begin
                    $display("%0t: back_depth expected %0d actual %0d",
                             $time, want.back_depth, got.back_depth);
                    errors++;
                end
                if (got.fwd_depth !== want.fwd_depth) begin
                    $display("%0t: forward_depth expected %0d actual %0d",
                             $time, want.fwd_depth, got.fwd_depth);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, pending_views.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_history();
        test_visit_extremes();
        test_back_forward();
        test_random_nav();
        test_back_stack_full();

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: empty-stack moves, extreme handles, back/forward walks,",
                 results_seen);
        $display("%0d random commands, and a full back stack with %0d dropped pushes",
                 RAND_ITEMS, full_drops);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
